@@ src/cbfd_pkg.sv @@
// ---------------------------------------------------------------------------
// Cubic Bezier forward-difference package
// Shared constants, controller states and the command and status bundles
// that join the controller to the datapath.
// ---------------------------------------------------------------------------
package cbfd_pkg;

    // Default parameter values for the top level.
    localparam int MAX_STEPS_DEF   = 63;
    localparam int COORD_WIDTH_DEF = 16;

    // Fixed field and port widths.
    localparam int STEP_W     = 6;
    localparam int NUM_AXES   = 3;
    localparam int CFG_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register map: index taken from the word address bits of paddr.
    localparam logic REG_IDX_STEP_COUNT = 1'b0;
    localparam logic [STEP_W-1:0] STEP_COUNT_RESET = 6'd16;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP_COEF,
        S_SETUP_CUBE,
        S_MULT,
        S_LOAD,
        S_DIV_START,
        S_DIV_WAIT,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic setup_coef;
        logic setup_cube;
        logic mult;
        logic load;
        logic div_start;
        logic emit;
        logic step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic div_done;
        logic out_free;
        logic last;
    } t_dp_status;

endpackage

@@ src/cbfd_curve_if.sv @@
// ---------------------------------------------------------------------------
// Curve input channel
// Valid/ready channel carrying the four 3D control points of one curve.
// ---------------------------------------------------------------------------
interface cbfd_curve_if #(
    parameter int COORD_WIDTH = cbfd_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] start_z;
    logic signed [COORD_WIDTH-1:0] handle1_x;
    logic signed [COORD_WIDTH-1:0] handle1_y;
    logic signed [COORD_WIDTH-1:0] handle1_z;
    logic signed [COORD_WIDTH-1:0] handle2_x;
    logic signed [COORD_WIDTH-1:0] handle2_y;
    logic signed [COORD_WIDTH-1:0] handle2_z;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] end_z;

    modport source (
        output valid, start_x, start_y, start_z, handle1_x, handle1_y, handle1_z,
               handle2_x, handle2_y, handle2_z, end_x, end_y, end_z,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, start_z, handle1_x, handle1_y, handle1_z,
               handle2_x, handle2_y, handle2_z, end_x, end_y, end_z,
        output ready
    );
endinterface

@@ src/cbfd_point_if.sv @@
// ---------------------------------------------------------------------------
// Curve point output channel
// Valid/ready channel carrying one rounded curve point with its index.
// ---------------------------------------------------------------------------
interface cbfd_point_if #(
    parameter int COORD_WIDTH = cbfd_pkg::COORD_WIDTH_DEF
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_WIDTH-1:0]     point_x;
    logic signed [COORD_WIDTH-1:0]     point_y;
    logic signed [COORD_WIDTH-1:0]     point_z;
    logic [cbfd_pkg::STEP_W-1:0]       point_index;
    logic                              last_point;

    modport source (
        output valid, point_x, point_y, point_z, point_index, last_point,
        input  ready
    );

    modport sink (
        input  valid, point_x, point_y, point_z, point_index, last_point,
        output ready
    );
endinterface

@@ src/cbfd_divider.sv @@
// ---------------------------------------------------------------------------
// Rounding divider
// Restoring divider, one quotient bit per cycle, giving the floor of a
// signed numerator over a positive denominator, saturated to the
// coordinate range.
// ---------------------------------------------------------------------------
module cbfd_divider #(
    parameter int NUM_W       = 40,
    parameter int DEN_W       = 19,
    parameter int COORD_WIDTH = cbfd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [NUM_W-1:0]       i_num,
    input  logic [DEN_W-1:0]              i_den,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_quot
);
    localparam int QW    = COORD_WIDTH - 1;
    localparam int MW    = NUM_W - 1;
    localparam int CNT_W = $clog2(QW + 1);

    logic [MW-1:0]    m_in;
    logic [MW-1:0]    head;
    logic             ovf;
    logic [DEN_W:0]   rem2;
    logic [DEN_W:0]   diff;
    logic             ge;

    logic [MW-1:0]    r_m;
    logic             r_neg;
    logic             r_ovf;
    logic [DEN_W-1:0] r_rem;
    logic [QW-1:0]    r_sh;
    logic [QW-1:0]    r_q;
    logic             r_load;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    // A negative numerator is folded: floor(n/d) = ~floor(~n/d).
    assign m_in = i_num[NUM_W-1] ? ~i_num[MW-1:0] : i_num[MW-1:0];

    // Bits above the quotient field; if they reach the divisor the result saturates.
    assign head = r_m >> QW;
    assign ovf  = head >= MW'(i_den);

    // One restoring step.
    assign rem2 = {r_rem, r_sh[QW-1]};
    assign ge   = rem2 >= {1'b0, i_den};
    assign diff = rem2 - {1'b0, i_den};

    // Iteration control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_load <= i_start;
            if (r_load) begin
                r_cnt <= CNT_W'(QW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
            r_done <= (r_cnt == CNT_W'(1)) && !r_load;
        end
    end

    // Operand capture and the shift-subtract datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m   <= m_in;
            r_neg <= i_num[NUM_W-1];
        end
        if (r_load) begin
            r_ovf <= ovf;
            r_rem <= head[DEN_W-1:0];
            r_sh  <= r_m[QW-1:0];
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
            r_q   <= {r_q[QW-2:0], ge};
            r_sh  <= {r_sh[QW-2:0], 1'b0};
        end
    end

    // Unfold the sign and saturate.
    always_comb begin
        if (r_ovf) begin
            o_quot = r_neg ? {1'b1, {QW{1'b0}}} : {1'b0, {QW{1'b1}}};
        end else begin
            o_quot = r_neg ? ~{1'b0, r_q} : {1'b0, r_q};
        end
    end

    assign o_done = r_done;

endmodule

@@ src/cbfd_ctrl.sv @@
// ---------------------------------------------------------------------------
// Cubic Bezier controller
// Sequences coefficient setup, the per-point rounding division, the
// output transaction and the forward-difference step.
// ---------------------------------------------------------------------------
module cbfd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbfd_pkg::t_dp_status i_status,
    output cbfd_pkg::t_dp_cmd    o_cmd
);
    import cbfd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_status.in_valid) n_state = S_SETUP_COEF;
            end
            S_SETUP_COEF: n_state = S_SETUP_CUBE;
            S_SETUP_CUBE: n_state = S_MULT;
            S_MULT:       n_state = S_LOAD;
            S_LOAD:       n_state = S_DIV_START;
            S_DIV_START:  n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (i_status.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = i_status.last ? S_IDLE : S_DIV_START;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:       o_cmd.in_ready   = 1'b1;
            S_SETUP_COEF: o_cmd.setup_coef = 1'b1;
            S_SETUP_CUBE: o_cmd.setup_cube = 1'b1;
            S_MULT:       o_cmd.mult       = 1'b1;
            S_LOAD:       o_cmd.load       = 1'b1;
            S_DIV_START:  o_cmd.div_start  = 1'b1;
            S_DIV_WAIT:   o_cmd            = '0;
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.step = !i_status.last;
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ src/cbfd_datapath.sv @@
// ---------------------------------------------------------------------------
// Cubic Bezier datapath
// Control point capture, polynomial coefficients scaled by powers of the
// step count, three cascaded accumulators per axis, rounding dividers and
// the output register.
// ---------------------------------------------------------------------------
module cbfd_datapath #(
    parameter int MAX_STEPS   = cbfd_pkg::MAX_STEPS_DEF,
    parameter int COORD_WIDTH = cbfd_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [cbfd_pkg::STEP_W-1:0] i_step_count,
    input  cbfd_pkg::t_dp_cmd           i_cmd,
    output cbfd_pkg::t_dp_status        o_status,
    cbfd_curve_if.sink                  i_curve,
    cbfd_point_if.source                o_point
);
    import cbfd_pkg::*;

    localparam int NW    = $clog2(MAX_STEPS + 1);
    localparam int N2W   = 2 * NW;
    localparam int N3W   = 3 * NW;
    localparam int CFW   = COORD_WIDTH + 4;
    localparam int ACC_W = COORD_WIDTH + N3W + 4;
    localparam int NUM_W = ACC_W + 2;
    localparam int DEN_W = N3W + 1;

    logic                          in_fire;
    logic [STEP_W-1:0]             n_clamped;
    logic signed [COORD_WIDTH-1:0] in_p0 [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] in_p1 [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] in_p2 [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] in_p3 [NUM_AXES];
    logic signed [NW:0]            n_s;
    logic signed [N2W:0]           n2_s;
    logic signed [N3W:0]           n3_s;
    logic [DEN_W-1:0]              den;
    logic signed [COORD_WIDTH-1:0] quot [NUM_AXES];
    logic [NUM_AXES-1:0]           done_vec;
    logic                          last;
    logic                          out_free;

    logic signed [COORD_WIDTH-1:0] r_p0 [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_p1 [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_p2 [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_p3 [NUM_AXES];
    logic [NW-1:0]                 r_n;
    logic [N2W-1:0]                r_n2;
    logic [N3W-1:0]                r_n3;
    logic [NW-1:0]                 r_k;
    logic                          r_out_valid;
    logic signed [COORD_WIDTH-1:0] r_pt_x;
    logic signed [COORD_WIDTH-1:0] r_pt_y;
    logic signed [COORD_WIDTH-1:0] r_pt_z;
    logic [STEP_W-1:0]             r_index;
    logic                          r_last;

    // Input transaction and per-axis views of the payload.
    assign i_curve.ready = i_cmd.in_ready;
    assign in_fire       = i_cmd.in_ready & i_curve.valid;

    assign in_p0[0] = i_curve.start_x;
    assign in_p0[1] = i_curve.start_y;
    assign in_p0[2] = i_curve.start_z;
    assign in_p1[0] = i_curve.handle1_x;
    assign in_p1[1] = i_curve.handle1_y;
    assign in_p1[2] = i_curve.handle1_z;
    assign in_p2[0] = i_curve.handle2_x;
    assign in_p2[1] = i_curve.handle2_y;
    assign in_p2[2] = i_curve.handle2_z;
    assign in_p3[0] = i_curve.end_x;
    assign in_p3[1] = i_curve.end_y;
    assign in_p3[2] = i_curve.end_z;

    // A zero step count behaves as one; large counts clamp to the maximum.
    always_comb begin
        if (i_step_count == '0) begin
            n_clamped = STEP_W'(1);
        end else if (i_step_count > STEP_W'(MAX_STEPS)) begin
            n_clamped = STEP_W'(MAX_STEPS);
        end else begin
            n_clamped = i_step_count;
        end
    end

    // Capture, powers of N and the point index.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_n <= n_clamped[NW-1:0];
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_p0[ax] <= in_p0[ax];
                r_p1[ax] <= in_p1[ax];
                r_p2[ax] <= in_p2[ax];
                r_p3[ax] <= in_p3[ax];
            end
        end
        if (i_cmd.setup_coef) begin
            r_n2 <= {{NW{1'b0}}, r_n} * {{NW{1'b0}}, r_n};
        end
        if (i_cmd.setup_cube) begin
            r_n3 <= {{NW{1'b0}}, r_n2} * {{N2W{1'b0}}, r_n};
        end
        if (i_cmd.load) begin
            r_k <= '0;
        end else if (i_cmd.step) begin
            r_k <= r_k + 1'b1;
        end
    end

    assign n_s  = $signed({1'b0, r_n});
    assign n2_s = $signed({1'b0, r_n2});
    assign n3_s = $signed({1'b0, r_n3});
    assign den  = {r_n3, 1'b0};
    assign last = (r_k == r_n);

    // One lane per axis: coefficients, products, accumulators, divider.
    for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_axis
        logic signed [CFW-1:0]             e0, e1, e2, e3;
        logic signed [CFW-1:0]             d12, s012, d01;
        logic signed [COORD_WIDTH+N3W:0]   pos_prod;
        logic signed [CFW+NW:0]            bn_prod;
        logic signed [CFW+N2W:0]           cn2_prod;
        logic signed [ACC_W-1:0]           a_ext;
        logic signed [ACC_W-1:0]           a6;
        logic signed [ACC_W-1:0]           bn_ext;
        logic signed [NUM_W-1:0]           num;

        logic signed [CFW-1:0]             r_a, r_b, r_c;
        logic signed [COORD_WIDTH+N3W:0]   r_pos_m;
        logic signed [CFW+NW:0]            r_bn;
        logic signed [CFW+N2W:0]           r_cn2;
        logic signed [ACC_W-1:0]           r_pos, r_d1, r_d2, r_d3;

        // Polynomial coefficients: a = P3 - P0 + 3(P1 - P2),
        // b = 3(P0 - 2 P1 + P2), c = 3(P1 - P0).
        assign e0   = CFW'(r_p0[ax]);
        assign e1   = CFW'(r_p1[ax]);
        assign e2   = CFW'(r_p2[ax]);
        assign e3   = CFW'(r_p3[ax]);
        assign d12  = e1 - e2;
        assign s012 = e0 - (e1 <<< 1) + e2;
        assign d01  = e1 - e0;

        // Scaling products, each registered before use.
        assign pos_prod = r_p0[ax] * n3_s;
        assign bn_prod  = r_b * n_s;
        assign cn2_prod = r_c * n2_s;

        assign a_ext  = ACC_W'(r_a);
        assign a6     = (a_ext <<< 2) + (a_ext <<< 1);
        assign bn_ext = ACC_W'(r_bn);

        always_ff @(posedge i_clk) begin
            if (i_cmd.setup_coef) begin
                r_a <= e3 - e0 + (d12 <<< 1) + d12;
                r_b <= (s012 <<< 1) + s012;
                r_c <= (d01 <<< 1) + d01;
            end
            if (i_cmd.mult) begin
                r_pos_m <= pos_prod;
                r_bn    <= bn_prod;
                r_cn2   <= cn2_prod;
            end
            // Accumulators: loaded for the first point, stepped afterwards.
            if (i_cmd.load) begin
                r_pos <= ACC_W'(r_pos_m);
                r_d1  <= a_ext + bn_ext + ACC_W'(r_cn2);
                r_d2  <= a6 + (bn_ext <<< 1);
                r_d3  <= a6;
            end else if (i_cmd.step) begin
                r_pos <= r_pos + r_d1;
                r_d1  <= r_d1 + r_d2;
                r_d2  <= r_d2 + r_d3;
            end
        end

        // Round half up: floor((2 pos + N^3) / (2 N^3)).
        assign num = {r_pos[ACC_W-1], r_pos, 1'b0} + {2'b00, {(ACC_W-N3W){1'b0}}, r_n3};

        cbfd_divider #(
            .NUM_W       (NUM_W),
            .DEN_W       (DEN_W),
            .COORD_WIDTH (COORD_WIDTH)
        ) u_divider (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (i_cmd.div_start),
            .i_num   (num),
            .i_den   (den),
            .o_done  (done_vec[ax]),
            .o_quot  (quot[ax])
        );
    end

    // Output register: refilled once the waiting transaction has gone.
    assign out_free = !r_out_valid | o_point.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_point.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pt_x  <= quot[0];
            r_pt_y  <= quot[1];
            r_pt_z  <= quot[2];
            r_index <= STEP_W'(r_k);
            r_last  <= last;
        end
    end

    assign o_point.valid       = r_out_valid;
    assign o_point.point_x     = r_pt_x;
    assign o_point.point_y     = r_pt_y;
    assign o_point.point_z     = r_pt_z;
    assign o_point.point_index = r_index;
    assign o_point.last_point  = r_last;

    // Status to the controller.
    assign o_status.in_valid = i_curve.valid;
    assign o_status.div_done = &done_vec;
    assign o_status.out_free = out_free;
    assign o_status.last     = last;

endmodule

@@ src/cubic_bezier_forward_difference.sv @@
// ---------------------------------------------------------------------------
// Cubic Bezier forward-difference curve generator
// Takes four 3D control points per curve and emits N+1 rounded curve points,
// N being step_count held to 1..MAX_STEPS, by exact scaled accumulators.
// ---------------------------------------------------------------------------
//
//  Channel   Dir   Handshake        Carries
//  i_curve   in    valid/ready      start, handle1, handle2, end (x, y, z)
//  o_point   out   valid/ready      point x/y/z, point_index, last_point
//  APB       in    psel/penable     step_count at byte address 0
//
// A curve passes through setup of the coefficients, the powers of N, the
// scaling products and the accumulator load; each point then waits on the
// rounding dividers, which produce one quotient bit per cycle. A new curve
// is taken once the last point of the previous one sits in the output
// register. A stalled output holds the point in its register; the next
// point waits until that transaction is done. Reset is synchronous, active
// low, and sets step_count to 16.
// ---------------------------------------------------------------------------
module cubic_bezier_forward_difference #(
    parameter int MAX_STEPS   = cbfd_pkg::MAX_STEPS_DEF,
    parameter int COORD_WIDTH = cbfd_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cbfd_curve_if.sink                      i_curve,
    cbfd_point_if.source                    o_point,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cbfd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [cbfd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cbfd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import cbfd_pkg::*;

    logic              reg_idx;
    logic              cfg_write;
    logic [STEP_W-1:0] r_step_count;
    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;

    // Configuration port: word index from the upper address bit.
    assign reg_idx   = paddr[APB_ADDR_W-1];
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= STEP_COUNT_RESET;
        end else if (cfg_write && (reg_idx == REG_IDX_STEP_COUNT)) begin
            r_step_count <= pwdata[STEP_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_IDX_STEP_COUNT: prdata = CFG_DATA_W'(r_step_count);
            default:            prdata = '0;
        endcase
    end

    // Controller.
    cbfd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // Datapath.
    cbfd_datapath #(
        .MAX_STEPS   (MAX_STEPS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step_count (r_step_count),
        .i_cmd        (dp_cmd),
        .o_status     (dp_status),
        .i_curve      (i_curve),
        .o_point      (o_point)
    );

endmodule
